// ----- src/q2e_pkg.sv -----
package q2e_pkg;

   // Field and datapath widths.
   localparam int CompW = 16;
   localparam int ProdW = 32;
   localparam int SumW = 34;
   localparam int VecW = 36;
   localparam int AngW = 26;
   localparam int RootW = 29;
   localparam int RadW = 58;
   localparam int RemW = 30;
   localparam int MagW = 28;
   localparam int OutW = 16;
   localparam int PitchW = 15;

   // Pipeline geometry.
   localparam int CordicStagesDef = 16;
   localparam int AngleTableLen = 24;
   localparam int SqrtStages = RadW / 2;

   // Angle constants, degrees scaled by 65536 or by 128.
   localparam int Deg90Q16 = 90 * 65536;
   localparam int Deg180Out = 23040;
   localparam int Deg90Out = 11520;
   localparam longint OneQ28 = 64'sd1 << 28;

   // One CORDIC vectoring cell's state.
   typedef struct packed {
      logic signed [VecW-1:0] x;
      logic signed [VecW-1:0] y;
      logic signed [AngW-1:0] z;
      logic                   zero;
   } cordic_type;

   // One square-root cell's state.
   typedef struct packed {
      logic [RadW-1:0]  rad;
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
   } sqrt_type;

   // atan(2^-i) in degrees times 65536, rounded.
   function automatic logic signed [AngW-1:0] atan_q16(input int idx);
      logic signed [AngW-1:0] v;
      case (idx)
         0:  v = AngW'(2949120);
         1:  v = AngW'(1740967);
         2:  v = AngW'(919879);
         3:  v = AngW'(466945);
         4:  v = AngW'(234379);
         5:  v = AngW'(117304);
         6:  v = AngW'(58666);
         7:  v = AngW'(29335);
         8:  v = AngW'(14668);
         9:  v = AngW'(7334);
         10: v = AngW'(3667);
         11: v = AngW'(1833);
         12: v = AngW'(917);
         13: v = AngW'(458);
         14: v = AngW'(229);
         15: v = AngW'(115);
         16: v = AngW'(57);
         17: v = AngW'(29);
         18: v = AngW'(14);
         19: v = AngW'(7);
         20: v = AngW'(4);
         21: v = AngW'(2);
         22: v = AngW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- src/q2e_channels.sv -----
// Quaternion word channel.
interface q2e_req_if import q2e_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [CompW-1:0] comp_w;
   logic signed [CompW-1:0] comp_x;
   logic signed [CompW-1:0] comp_y;
   logic signed [CompW-1:0] comp_z;

   modport source (output valid, comp_w, comp_x, comp_y, comp_z, input ready);
   modport sink (input valid, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface

// Euler angle word channel.
interface q2e_rsp_if import q2e_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [OutW-1:0]   roll_deg;
   logic signed [PitchW-1:0] pitch_deg;
   logic signed [OutW-1:0]   yaw_deg;
   logic                     pitch_clamped;

   modport source (output valid, roll_deg, pitch_deg, yaw_deg, pitch_clamped, input ready);
   modport sink (input valid, roll_deg, pitch_deg, yaw_deg, pitch_clamped, output ready);
endinterface

// ----- src/quaternion_to_euler_angles.sv -----
// Quaternion to roll, pitch and yaw converter.
// req_chan carries one attitude quaternion (w, x, y, z) in signed Q1.14 per
// word; rsp_chan returns roll, pitch and yaw in degrees times 128 together
// with a flag that is set when the pitch sine reached plus or minus one and
// pitch was saturated to ninety degrees.
// The block is a single pipeline: a product stage, a sum stage, a square
// stage, a radicand stage, 29 square-root cells, then for each angle a
// quadrant fold, CORDIC_STAGES vectoring cells and a rounding stage.
// One word is taken every cycle unless the receiver stalls; the rate is
// set by the row of cells, each of which holds one word.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_chan.ready drops; a word may still enter in the same cycle as the
// waiting result is taken. Synchronous reset empties the pipeline; no other
// state is kept.
module quaternion_to_euler_angles import q2e_pkg::*; #(
   parameter int CORDIC_STAGES = CordicStagesDef
) (
   input  logic      clock,
   input  logic      reset,
   q2e_req_if.sink   req_chan,
   q2e_rsp_if.source rsp_chan
);

   localparam int SumDelay = SqrtStages + 2;
   localparam int FlagDelay = SumDelay + CORDIC_STAGES + 3;
   localparam int NumStg = SumDelay + 2 + CORDIC_STAGES + 2;
   localparam logic signed [SumW-1:0] OnePos = SumW'(OneQ28);
   localparam logic signed [SumW-1:0] OneNeg = -SumW'(OneQ28);

   typedef struct packed {
      logic signed [SumW-1:0] sinr;
      logic signed [SumW-1:0] cosr;
      logic signed [SumW-1:0] sinp;
      logic signed [SumW-1:0] siny;
      logic signed [SumW-1:0] cosy;
   } sums_type;

   typedef struct packed {
      logic clamp;
      logic neg;
   } flag_type;

   logic                    adv;
   logic [NumStg-1:0]       vld_ff;
   logic [NumStg-1:0]       vld_in;

   logic signed [ProdW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   logic signed [SumW-2:0]  h_sinr, h_sinp, h_siny, h_xy2, h_yz2;
   sums_type                sums_in;
   sums_type                sums_ff;
   flag_type                flag_in;
   sums_type                sdl_ff [SumDelay];
   flag_type                fdl_ff [FlagDelay];

   logic signed [SumW-1:0]  sinp_abs;
   logic [2*MagW-1:0]       sq_in;
   logic [2*MagW-1:0]       sq_ff;
   sqrt_type                sq_st [SqrtStages+1];
   logic signed [SumW-1:0]  root_x;

   logic signed [OutW-1:0]  roll_q;
   logic signed [OutW-1:0]  pitch_q;
   logic signed [OutW-1:0]  yaw_q;
   flag_type                flag_out;

   // Whole pipeline moves unless a result waits on a stalled receiver.
   assign adv = !vld_ff[NumStg-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      vld_in = {vld_ff[NumStg-2:0], req_chan.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Products of the components, all exact.
   always_ff @(posedge clock) begin
      if (adv) begin
         wx_ff <= req_chan.comp_w * req_chan.comp_x;
         yz_ff <= req_chan.comp_y * req_chan.comp_z;
         xx_ff <= req_chan.comp_x * req_chan.comp_x;
         yy_ff <= req_chan.comp_y * req_chan.comp_y;
         wy_ff <= req_chan.comp_w * req_chan.comp_y;
         zx_ff <= req_chan.comp_z * req_chan.comp_x;
         wz_ff <= req_chan.comp_w * req_chan.comp_z;
         xy_ff <= req_chan.comp_x * req_chan.comp_y;
         zz_ff <= req_chan.comp_z * req_chan.comp_z;
      end
   end

   // Sines and cosines in Q28, and the pitch saturation test.
   always_comb begin
      h_sinr = (SumW-1)'(wx_ff) + (SumW-1)'(yz_ff);
      h_sinp = (SumW-1)'(wy_ff) - (SumW-1)'(zx_ff);
      h_siny = (SumW-1)'(wz_ff) + (SumW-1)'(xy_ff);
      h_xy2 = (SumW-1)'(xx_ff) + (SumW-1)'(yy_ff);
      h_yz2 = (SumW-1)'(yy_ff) + (SumW-1)'(zz_ff);
      sums_in.sinr = {h_sinr, 1'b0};
      sums_in.sinp = {h_sinp, 1'b0};
      sums_in.siny = {h_siny, 1'b0};
      sums_in.cosr = OnePos - {h_xy2, 1'b0};
      sums_in.cosy = OnePos - {h_yz2, 1'b0};
      flag_in.clamp = (sums_in.sinp >= OnePos) || (sums_in.sinp <= OneNeg);
      flag_in.neg = sums_in.sinp[SumW-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sums_ff <= sums_in;
         fdl_ff[0] <= flag_in;
      end
   end

   // Sums wait here while the pitch cosine is worked out.
   always_ff @(posedge clock) begin
      if (adv) begin
         sdl_ff[0] <= sums_ff;
         for (int k = 1; k < SumDelay; k++) begin
            sdl_ff[k] <= sdl_ff[k-1];
         end
         for (int k = 1; k < FlagDelay; k++) begin
            fdl_ff[k] <= fdl_ff[k-1];
         end
      end
   end

   // Square of the pitch sine; its magnitude is below one when it matters.
   always_comb begin
      sinp_abs = sums_ff.sinp[SumW-1] ? -sums_ff.sinp : sums_ff.sinp;
      sq_in = sinp_abs[MagW-1:0] * sinp_abs[MagW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= sq_in;
      end
   end

   // Radicand one minus sine squared, in Q56.
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_st[0].rad <= (RadW'(1) << (2 * MagW)) - RadW'(sq_ff);
         sq_st[0].rem <= '0;
         sq_st[0].root <= '0;
      end
   end

   // Row of square-root cells, one root bit each.
   for (genvar i = 0; i < SqrtStages; i++) begin : g_sqrt
      q2e_sqrt_cell u_cell (
         .clock  (clock),
         .adv    (adv),
         .cur    (sq_st[i]),
         .nxt_ff (sq_st[i+1])
      );
   end

   assign root_x = SumW'(sq_st[SqrtStages].root);

   // Three angle units.
   q2e_atan2 #(.STAGES(CORDIC_STAGES), .LIM(Deg180Out)) u_roll (
      .clock    (clock),
      .adv      (adv),
      .y_in     (sdl_ff[SumDelay-1].sinr),
      .x_in     (sdl_ff[SumDelay-1].cosr),
      .angle_ff (roll_q)
   );

   q2e_atan2 #(.STAGES(CORDIC_STAGES), .LIM(Deg90Out)) u_pitch (
      .clock    (clock),
      .adv      (adv),
      .y_in     (sdl_ff[SumDelay-1].sinp),
      .x_in     (root_x),
      .angle_ff (pitch_q)
   );

   q2e_atan2 #(.STAGES(CORDIC_STAGES), .LIM(Deg180Out)) u_yaw (
      .clock    (clock),
      .adv      (adv),
      .y_in     (sdl_ff[SumDelay-1].siny),
      .x_in     (sdl_ff[SumDelay-1].cosy),
      .angle_ff (yaw_q)
   );

   // Result word; a saturated pitch replaces the CORDIC angle.
   assign flag_out = fdl_ff[FlagDelay-1];
   assign rsp_chan.valid = vld_ff[NumStg-1];
   assign rsp_chan.roll_deg = roll_q;
   assign rsp_chan.yaw_deg = yaw_q;
   assign rsp_chan.pitch_clamped = flag_out.clamp;

   always_comb begin
      if (flag_out.clamp) begin
         rsp_chan.pitch_deg = flag_out.neg ? -PitchW'(Deg90Out) : PitchW'(Deg90Out);
      end else begin
         rsp_chan.pitch_deg = pitch_q[PitchW-1:0];
      end
   end

endmodule

// ----- src/q2e_sqrt_cell.sv -----
module q2e_sqrt_cell import q2e_pkg::*; (
   input  logic     clock,
   input  logic     adv,
   input  sqrt_type cur,
   output sqrt_type nxt_ff
);

   logic [RemW+1:0] rem_sh;
   logic [RemW+1:0] trial;
   logic [RemW+1:0] diff;
   logic            ge;
   sqrt_type        nxt_in;

   // One root bit: bring down two radicand bits and try the subtraction.
   always_comb begin
      rem_sh = {cur.rem, cur.rad[RadW-1 -: 2]};
      trial = {1'b0, cur.root, 2'b01};
      diff = rem_sh - trial;
      ge = (rem_sh >= trial);
      nxt_in.rad = {cur.rad[RadW-3:0], 2'b00};
      nxt_in.rem = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
      nxt_in.root = {cur.root[RootW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nxt_ff <= nxt_in;
      end
   end

endmodule

// ----- src/q2e_cordic_cell.sv -----
module q2e_cordic_cell import q2e_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  logic       clock,
   input  logic       adv,
   input  cordic_type cur,
   output cordic_type nxt_ff
);

   logic signed [VecW-1:0] dx;
   logic signed [VecW-1:0] dy;
   logic signed [AngW-1:0] ang;
   cordic_type             nxt_in;

   // One vectoring micro-rotation towards the positive x axis.
   always_comb begin
      dx = cur.y >>> SHIFT;
      dy = cur.x >>> SHIFT;
      ang = atan_q16(SHIFT);
      nxt_in.zero = cur.zero;
      if (!cur.y[VecW-1]) begin
         nxt_in.x = cur.x + dx;
         nxt_in.y = cur.y - dy;
         nxt_in.z = cur.z + ang;
      end else begin
         nxt_in.x = cur.x - dx;
         nxt_in.y = cur.y + dy;
         nxt_in.z = cur.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nxt_ff <= nxt_in;
      end
   end

endmodule

// ----- src/q2e_atan2.sv -----
module q2e_atan2 import q2e_pkg::*; #(
   parameter int STAGES = CordicStagesDef,
   parameter int LIM = Deg180Out
) (
   input  logic                   clock,
   input  logic                   adv,
   input  logic signed [SumW-1:0] y_in,
   input  logic signed [SumW-1:0] x_in,
   output logic signed [OutW-1:0] angle_ff
);

   localparam logic signed [AngW:0] LimPos = (AngW+1)'(LIM);
   localparam logic signed [AngW:0] LimNeg = -(AngW+1)'(LIM);

   logic signed [VecW-1:0] xe;
   logic signed [VecW-1:0] ye;
   cordic_type             pre_in;
   cordic_type             cell_q [STAGES+1];
   logic signed [AngW:0]   zsum;
   logic signed [AngW:0]   rnd;
   logic signed [OutW-1:0] angle_in;

   // Fold the left half plane onto the right one by a quarter turn.
   always_comb begin
      xe = VecW'(x_in);
      ye = VecW'(y_in);
      pre_in.zero = (x_in == '0) && (y_in == '0);
      if (x_in[SumW-1]) begin
         if (!y_in[SumW-1]) begin
            pre_in.z = AngW'(Deg90Q16);
            pre_in.x = ye;
            pre_in.y = -xe;
         end else begin
            pre_in.z = -AngW'(Deg90Q16);
            pre_in.x = -ye;
            pre_in.y = xe;
         end
      end else begin
         pre_in.z = '0;
         pre_in.x = xe;
         pre_in.y = ye;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cell_q[0] <= pre_in;
      end
   end

   // Row of micro-rotation cells.
   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      q2e_cordic_cell #(.SHIFT(i)) u_cell (
         .clock  (clock),
         .adv    (adv),
         .cur    (cell_q[i]),
         .nxt_ff (cell_q[i+1])
      );
   end

   // Round to 1/128 degree and saturate; a zero vector gives angle zero.
   always_comb begin
      zsum = (AngW+1)'(cell_q[STAGES].z) + (AngW+1)'(256);
      rnd = zsum >>> 9;
      if (cell_q[STAGES].zero) begin
         angle_in = '0;
      end else if (rnd > LimPos) begin
         angle_in = OutW'(LimPos);
      end else if (rnd < LimNeg) begin
         angle_in = OutW'(LimNeg);
      end else begin
         angle_in = OutW'(rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= angle_in;
      end
   end

endmodule
